[rtl/two_level_weighted_rotating_queue_macros.svh]
// Assertion helpers for the RTL, included by tlwrq_dpath.sv.
`ifndef TWO_LEVEL_WEIGHTED_ROTATING_QUEUE_MACROS_SVH
`define TWO_LEVEL_WEIGHTED_ROTATING_QUEUE_MACROS_SVH

// Same-cycle implication, clocked on aclk, off while in reset.
`define TLWRQ_ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("tlwrq: check failed");

// Next-cycle implication, clocked on aclk, off while in reset.
`define TLWRQ_ASSERT_NXT(name, pre, post) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("tlwrq: check failed");

`endif

[rtl/tlwrq_pkg.sv]
`default_nettype none

package tlwrq_pkg;

    localparam int ITEM_W = 16;     // item_id / item_out field width
    localparam int MODE_W = 2;      // mode field width
    localparam int STAT_W = 2;      // status field width
    localparam int SLOT_W = 4;

    // dequeue slot that prefers the low ring; counter wraps after it
    localparam logic [SLOT_W-1:0] SLOT_LAST = 4'd9;

    typedef enum logic [MODE_W-1:0] {
        MODE_ENQ_HIGH = 2'd0,
        MODE_ENQ_LOW  = 2'd1,
        MODE_DEQ      = 2'd2,
        MODE_NOP      = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        RES_OK      = 2'd0,
        RES_IGNORED = 2'd1,
        RES_FULL    = 2'd2,
        RES_EMPTY   = 2'd3
    } res_t;

    typedef enum logic [2:0] {
        CTL_IDLE,
        CTL_DECODE,
        CTL_SCAN,
        CTL_ENQ,
        CTL_DEQ,
        CTL_OUT
    } ctl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;      // latch input transfer
        logic scan_start;   // clear duplicate scan
        logic scan_step;    // one scan entry per cycle
        logic enq_commit;   // finish enqueue
        logic deq_read;     // pick ring, read its head
        logic deq_commit;   // rotate head to tail
        logic set_ignore;   // null id or unused mode
        logic out_load;     // move result into output register
    } tlwrq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        mode_t mode;
        logic  id_null;
        logic  scan_done;
        logic  out_free;
    } tlwrq_stat_t;

endpackage

`default_nettype wire

[rtl/two_level_weighted_rotating_queue.sv]
// Enqueue: duplicate scan over both rings (one entry of each ring per cycle,
// each over its ring's single read port), then commit. Dequeue: read head, rotate.
// Null id or unused mode goes straight to the result. One item at a time: s_tready
// is high only while idle, so the next transfer waits until the result is loaded.
// Reset: aresetn synchronous, active low; rings empty, slot counter 0, no result.
`default_nettype none

module two_level_weighted_rotating_queue #(
    parameter int RING_DEPTH = 16,   // entries per ring, 2..256
    parameter int ID_WIDTH   = 16    // stored id bits, 4..64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input channel
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [tlwrq_pkg::ITEM_W-1:0]  s_tdata,   // [15:0] item_id
    input  wire logic [tlwrq_pkg::MODE_W-1:0]  s_tuser,   // [1:0] mode
    // result channel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [tlwrq_pkg::ITEM_W-1:0]       m_tdata,   // [15:0] item_out
    output logic [tlwrq_pkg::STAT_W:0]         m_tuser    // [0] item_valid, [2:1] status
);
    import tlwrq_pkg::*;

    // Controller walks one item at a time: capture, decode, then either
    // the duplicate scan + enqueue commit, or the dequeue read + rotate.
    // Result is parked in an output register so the next input transfer
    // can be taken while the result still waits on m_tready.
    tlwrq_cmd_t  cmd;
    tlwrq_stat_t stat;

    tlwrq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: both ring memories, head/fill pointers, slot counter,
    // scan compare and the output register.
    tlwrq_dpath #(
        .RING_DEPTH (RING_DEPTH),
        .ID_WIDTH   (ID_WIDTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

[rtl/tlwrq_dpath.sv]
`default_nettype none

`include "two_level_weighted_rotating_queue_macros.svh"

module tlwrq_dpath #(
    parameter int RING_DEPTH = 16,
    parameter int ID_WIDTH   = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tlwrq_pkg::tlwrq_cmd_t         cmd,
    output tlwrq_pkg::tlwrq_stat_t             stat,
    input  wire logic [tlwrq_pkg::ITEM_W-1:0]  s_tdata,
    input  wire logic [tlwrq_pkg::MODE_W-1:0]  s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [tlwrq_pkg::ITEM_W-1:0]       m_tdata,
    output logic [tlwrq_pkg::STAT_W:0]         m_tuser
);
    import tlwrq_pkg::*;

    localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;
    localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(RING_DEPTH);
    localparam logic [PTR_W-1:0]  LAST_P  = PTR_W'(RING_DEPTH - 1);

    // (base + off) mod depth, sum stays below twice the depth
    function automatic logic [PTR_W-1:0] ring_pos(input logic [PTR_W-1:0]  base,
                                                   input logic [FILL_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(RING_DEPTH)) begin
            sum = sum - SUM_W'(RING_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_P) ? '0 : p + 1'b1;
    endfunction

    // ring storage
    logic [ID_WIDTH-1:0] hi_mem [RING_DEPTH];
    logic [ID_WIDTH-1:0] lo_mem [RING_DEPTH];
    logic [ID_WIDTH-1:0] hi_rd_reg, lo_rd_reg;

    // control state
    logic [PTR_W-1:0]  hi_head_reg, hi_head_next, lo_head_reg, lo_head_next;
    logic [FILL_W-1:0] hi_fill_reg, hi_fill_next, lo_fill_reg, lo_fill_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              m_valid_reg, m_valid_next;

    // per-item working registers
    mode_t             mode_reg, mode_next;
    logic [ID_WIDTH-1:0] id_reg, id_next;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic              cmp_hv_reg, cmp_hv_next, cmp_lv_reg, cmp_lv_next;
    logic              hit_reg, hit_next;
    logic              sel_low_reg, sel_low_next, sel_empty_reg, sel_empty_next;
    logic [ID_WIDTH-1:0] res_item_reg, res_item_next;
    logic              res_valid_reg, res_valid_next;
    res_t              res_status_reg, res_status_next;
    logic [ID_WIDTH-1:0] m_item_reg, m_item_next;
    logic              m_ivalid_reg, m_ivalid_next;
    res_t              m_status_reg, m_status_next;

    logic [ID_WIDTH-1:0] id_in;
    logic [PTR_W-1:0]    hi_tail, lo_tail, hi_raddr, lo_raddr;
    logic [ID_WIDTH-1:0] deq_data, wdata;
    logic                enq_low, tgt_full, enq_ok, deq_ok, hi_we, lo_we, scan_done;

    // id field mapped onto the stored width
    for (genvar i = 0; i < ID_WIDTH; i++) begin : g_id_in
        if (i < ITEM_W) begin : g_bit
            assign id_in[i] = s_tdata[i];
        end else begin : g_zero
            assign id_in[i] = 1'b0;
        end
    end

    for (genvar j = 0; j < ITEM_W; j++) begin : g_out
        if (j < ID_WIDTH) begin : g_bit
            assign m_tdata[j] = m_item_reg[j];
        end else begin : g_zero
            assign m_tdata[j] = 1'b0;
        end
    end

    assign hi_tail   = ring_pos(hi_head_reg, hi_fill_reg);
    assign lo_tail   = ring_pos(lo_head_reg, lo_fill_reg);
    assign hi_raddr  = cmd.deq_read ? hi_head_reg : ring_pos(hi_head_reg, idx_reg);
    assign lo_raddr  = cmd.deq_read ? lo_head_reg : ring_pos(lo_head_reg, idx_reg);
    assign enq_low   = (mode_reg == MODE_ENQ_LOW);
    assign tgt_full  = enq_low ? (lo_fill_reg == DEPTH_F) : (hi_fill_reg == DEPTH_F);
    assign deq_data  = sel_low_reg ? lo_rd_reg : hi_rd_reg;
    assign enq_ok    = cmd.enq_commit && !hit_reg && !tgt_full;
    assign deq_ok    = cmd.deq_commit && !sel_empty_reg;
    assign hi_we     = (enq_ok && !enq_low) || (deq_ok && !sel_low_reg);
    assign lo_we     = (enq_ok && enq_low) || (deq_ok && sel_low_reg);
    assign wdata     = cmd.enq_commit ? id_reg : deq_data;
    assign scan_done = (idx_reg >= hi_fill_reg) && (idx_reg >= lo_fill_reg);

    assign stat.mode      = mode_reg;
    assign stat.id_null   = (id_reg == '0);
    assign stat.scan_done = scan_done;
    assign stat.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {m_status_reg, m_ivalid_reg};

    always_comb begin
        hi_head_next    = hi_head_reg;
        lo_head_next    = lo_head_reg;
        hi_fill_next    = hi_fill_reg;
        lo_fill_next    = lo_fill_reg;
        slot_next       = slot_reg;
        m_valid_next    = m_valid_reg;
        mode_next       = mode_reg;
        id_next         = id_reg;
        idx_next        = idx_reg;
        cmp_hv_next     = cmp_hv_reg;
        cmp_lv_next     = cmp_lv_reg;
        hit_next        = hit_reg;
        sel_low_next    = sel_low_reg;
        sel_empty_next  = sel_empty_reg;
        res_item_next   = res_item_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        m_item_next     = m_item_reg;
        m_ivalid_next   = m_ivalid_reg;
        m_status_next   = m_status_reg;

        if (cmd.capture) begin
            mode_next = mode_t'(s_tuser);
            id_next   = id_in;
        end

        if (cmd.scan_start) begin
            idx_next    = '0;
            hit_next    = 1'b0;
            cmp_hv_next = 1'b0;
            cmp_lv_next = 1'b0;
        end

        // compare last cycle's read, issue the next one
        if (cmd.scan_step) begin
            hit_next = hit_reg
                     | (cmp_hv_reg && (hi_rd_reg == id_reg))
                     | (cmp_lv_reg && (lo_rd_reg == id_reg));
            cmp_hv_next = (idx_reg < hi_fill_reg);
            cmp_lv_next = (idx_reg < lo_fill_reg);
            if (!scan_done) begin
                idx_next = idx_reg + 1'b1;
            end
        end

        if (cmd.deq_read) begin
            if (slot_reg == SLOT_LAST) begin
                sel_low_next = (lo_fill_reg != '0) || (hi_fill_reg == '0);
            end else begin
                sel_low_next = (hi_fill_reg == '0);
            end
            sel_empty_next = (hi_fill_reg == '0) && (lo_fill_reg == '0);
        end

        if (cmd.set_ignore) begin
            res_item_next   = '0;
            res_valid_next  = 1'b0;
            res_status_next = RES_IGNORED;
        end

        if (cmd.enq_commit) begin
            res_item_next  = '0;
            res_valid_next = 1'b0;
            if (hit_reg) begin
                res_status_next = RES_IGNORED;
            end else if (tgt_full) begin
                res_status_next = RES_FULL;
            end else begin
                res_status_next = RES_OK;
            end
            if (enq_ok && enq_low) begin
                lo_fill_next = lo_fill_reg + 1'b1;
            end
            if (enq_ok && !enq_low) begin
                hi_fill_next = hi_fill_reg + 1'b1;
            end
        end

        if (cmd.deq_commit) begin
            slot_next = (slot_reg >= SLOT_LAST) ? '0 : slot_reg + 1'b1;
            if (sel_empty_reg) begin
                res_item_next   = '0;
                res_valid_next  = 1'b0;
                res_status_next = RES_EMPTY;
            end else begin
                res_item_next   = deq_data;
                res_valid_next  = 1'b1;
                res_status_next = RES_OK;
                if (sel_low_reg) begin
                    lo_head_next = ptr_inc(lo_head_reg);
                end else begin
                    hi_head_next = ptr_inc(hi_head_reg);
                end
            end
        end

        if (cmd.out_load) begin
            m_valid_next  = 1'b1;
            m_item_next   = res_item_reg;
            m_ivalid_next = res_valid_reg;
            m_status_next = res_status_reg;
        end else if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hi_head_reg <= '0;
            lo_head_reg <= '0;
            hi_fill_reg <= '0;
            lo_fill_reg <= '0;
            slot_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            hi_head_reg <= hi_head_next;
            lo_head_reg <= lo_head_next;
            hi_fill_reg <= hi_fill_next;
            lo_fill_reg <= lo_fill_next;
            slot_reg    <= slot_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        id_reg         <= id_next;
        idx_reg        <= idx_next;
        cmp_hv_reg     <= cmp_hv_next;
        cmp_lv_reg     <= cmp_lv_next;
        hit_reg        <= hit_next;
        sel_low_reg    <= sel_low_next;
        sel_empty_reg  <= sel_empty_next;
        res_item_reg   <= res_item_next;
        res_valid_reg  <= res_valid_next;
        res_status_reg <= res_status_next;
        m_item_reg     <= m_item_next;
        m_ivalid_reg   <= m_ivalid_next;
        m_status_reg   <= m_status_next;
    end

    // ring memories: one write and one registered read per cycle each
    always_ff @(posedge aclk) begin
        if (hi_we) begin
            hi_mem[hi_tail] <= wdata;
        end
        hi_rd_reg <= hi_mem[hi_raddr];
    end

    always_ff @(posedge aclk) begin
        if (lo_we) begin
            lo_mem[lo_tail] <= wdata;
        end
        lo_rd_reg <= lo_mem[lo_raddr];
    end

    `TLWRQ_ASSERT_IMP(a_fill_bound, 1'b1, (hi_fill_reg <= DEPTH_F) && (lo_fill_reg <= DEPTH_F))
    `TLWRQ_ASSERT_IMP(a_slot_range, 1'b1, slot_reg <= SLOT_LAST)
    `TLWRQ_ASSERT_NXT(a_deq_result, deq_ok, res_valid_reg && (res_status_reg == RES_OK))
    `TLWRQ_ASSERT_NXT(a_enq_fill, enq_ok && !enq_low, hi_fill_reg == $past(hi_fill_reg) + 1'b1)

endmodule

`default_nettype wire

[rtl/tlwrq_ctrl.sv]
`default_nettype none

module tlwrq_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire tlwrq_pkg::tlwrq_stat_t  stat,
    output tlwrq_pkg::tlwrq_cmd_t        cmd
);
    import tlwrq_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       is_enq;

    assign is_enq = (stat.mode == MODE_ENQ_HIGH) || (stat.mode == MODE_ENQ_LOW);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CTL_IDLE: begin
                if (s_tvalid) begin
                    state_next = CTL_DECODE;
                end
            end
            CTL_DECODE: begin
                if (is_enq && !stat.id_null) begin
                    state_next = CTL_SCAN;
                end else if (stat.mode == MODE_DEQ) begin
                    state_next = CTL_DEQ;
                end else begin
                    state_next = CTL_OUT;
                end
            end
            CTL_SCAN: begin
                if (stat.scan_done) begin
                    state_next = CTL_ENQ;
                end
            end
            CTL_ENQ:    state_next = CTL_OUT;
            CTL_DEQ:    state_next = CTL_OUT;
            CTL_OUT: begin
                if (stat.out_free) begin
                    state_next = CTL_IDLE;
                end
            end
            default:    state_next = CTL_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            CTL_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            CTL_DECODE: begin
                if (is_enq && !stat.id_null) begin
                    cmd.scan_start = 1'b1;
                end else if (stat.mode == MODE_DEQ) begin
                    cmd.deq_read = 1'b1;
                end else begin
                    cmd.set_ignore = 1'b1;
                end
            end
            CTL_SCAN:  cmd.scan_step  = 1'b1;
            CTL_ENQ:   cmd.enq_commit = 1'b1;
            CTL_DEQ:   cmd.deq_commit = 1'b1;
            CTL_OUT:   cmd.out_load   = stat.out_free;
            default: begin
                cmd      = '0;
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[tb/sv/two_level_weighted_rotating_queue_tb.sv]
`timescale 1ns / 1ps

module two_level_weighted_rotating_queue_tb;
    import tlwrq_pkg::*;

    localparam int RING_SLOTS    = 16;     // entries per ring in the DUT build
    localparam int RING_HIGH     = 0;
    localparam int RING_LOW      = 1;
    localparam int QUIET_LIMIT   = 4000;   // cycles with no transfer on either side
    localparam int TAIL_CYCLES   = 40;     // wait after the last phase before the final check
    localparam int ITEMS_PER_PHASE = 500;

    // one result as the block reports it
    typedef struct packed {
        logic [ITEM_W-1:0] item;
        logic              valid;
        res_t              status;
    } outcome_t;

    // directed stimulus row; fixed = result typed in, else taken from the predictor
    typedef struct packed {
        mode_t             mode;
        logic [ITEM_W-1:0] id;
        logic              fixed;
        outcome_t          want;
    } stim_row_t;

    localparam int DIR_ROWS = 22;
    localparam stim_row_t DIRECTED [0:DIR_ROWS-1] = '{
        // empty block: dequeue reports both rings empty, slot still advances
        '{MODE_DEQ,      16'h0000, 1'b1, '{16'h0000, 1'b0, RES_EMPTY}},
        // null handle on both rings, unused mode
        '{MODE_ENQ_HIGH, 16'h0000, 1'b1, '{16'h0000, 1'b0, RES_IGNORED}},
        '{MODE_ENQ_LOW,  16'h0000, 1'b1, '{16'h0000, 1'b0, RES_IGNORED}},
        '{MODE_NOP,      16'h1234, 1'b1, '{16'h0000, 1'b0, RES_IGNORED}},
        // all-ones id into low ring, then the same id toward high is a duplicate
        '{MODE_ENQ_LOW,  16'hFFFF, 1'b1, '{16'h0000, 1'b0, RES_OK}},
        '{MODE_ENQ_HIGH, 16'hFFFF, 1'b1, '{16'h0000, 1'b0, RES_IGNORED}},
        // high empty: falls back to low; single item rotates onto itself
        '{MODE_DEQ,      16'h5A5A, 1'b1, '{16'hFFFF, 1'b1, RES_OK}},
        '{MODE_DEQ,      16'h0000, 1'b1, '{16'hFFFF, 1'b1, RES_OK}},
        '{MODE_ENQ_LOW,  16'h0001, 1'b1, '{16'h0000, 1'b0, RES_OK}},
        '{MODE_ENQ_HIGH, 16'h8000, 1'b1, '{16'h0000, 1'b0, RES_OK}},
        '{MODE_ENQ_HIGH, 16'h7FFE, 1'b1, '{16'h0000, 1'b0, RES_OK}},
        // walk the slot counter up to the low-priority slot and past it
        '{MODE_DEQ,      16'h0000, 1'b0, '0},
        '{MODE_DEQ,      16'hFFFF, 1'b0, '0},
        '{MODE_DEQ,      16'h0000, 1'b0, '0},
        '{MODE_DEQ,      16'h0000, 1'b0, '0},
        '{MODE_DEQ,      16'h0000, 1'b0, '0},
        '{MODE_DEQ,      16'h0000, 1'b0, '0},
        '{MODE_DEQ,      16'h0000, 1'b0, '0},
        '{MODE_DEQ,      16'h0000, 1'b0, '0},
        // duplicates across rings, unused mode with all-ones payload
        '{MODE_ENQ_HIGH, 16'h0001, 1'b1, '{16'h0000, 1'b0, RES_IGNORED}},
        '{MODE_NOP,      16'hFFFF, 1'b1, '{16'h0000, 1'b0, RES_IGNORED}},
        '{MODE_ENQ_LOW,  16'h8000, 1'b1, '{16'h0000, 1'b0, RES_IGNORED}}
    };

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [ITEM_W-1:0]   s_tdata  = '0;
    logic [MODE_W-1:0]   s_tuser  = MODE_NOP;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [ITEM_W-1:0]   m_tdata;
    logic [STAT_W:0]     m_tuser;

    // idle rates, percent of cycles
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // item on the input bus: typed result, if any
    logic     cur_fixed = 1'b0;
    outcome_t cur_want  = '0;

    // predictor state: rings indexed by RING_HIGH / RING_LOW
    logic [ITEM_W-1:0] ring_slots [2][RING_SLOTS];
    int unsigned       ring_head [2];
    int unsigned       ring_fill [2];
    logic [SLOT_W-1:0] deq_slot;

    outcome_t          pending_outcomes [$];
    logic [ITEM_W-1:0] enqueued_ids [$];
    int unsigned       mismatch_count = 0;
    int unsigned       quiet_cycles   = 0;

    two_level_weighted_rotating_queue #(
        .RING_DEPTH (RING_SLOTS),
        .ID_WIDTH   (ITEM_W)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [15:0] item_id
        .s_tuser  (s_tuser),    // [1:0] mode
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [15:0] item_out
        .m_tuser  (m_tuser)     // [0] item_valid, [2:1] status
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s: got %0h, want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Rotating-queue behavior for one accepted transfer; updates predictor state.
    function automatic outcome_t queue_step(input mode_t mode, input logic [ITEM_W-1:0] id);
        outcome_t    res;
        int          tgt;
        int          pref;
        logic        seen;
        int unsigned pos;
        res        = '0;
        res.status = RES_IGNORED;
        seen       = 1'b0;
        case (mode)
            MODE_ENQ_HIGH, MODE_ENQ_LOW: begin
                tgt = (mode == MODE_ENQ_HIGH) ? RING_HIGH : RING_LOW;
                // duplicate check spans both rings and runs before the full check
                for (int r = 0; r < 2; r++)
                    for (int unsigned k = 0; k < ring_fill[r]; k++)
                        if (ring_slots[r][(ring_head[r] + k) % RING_SLOTS] == id)
                            seen = 1'b1;
                if (id == '0 || seen) begin
                    res.status = RES_IGNORED;
                end else if (ring_fill[tgt] >= RING_SLOTS) begin
                    res.status = RES_FULL;
                end else begin
                    ring_slots[tgt][(ring_head[tgt] + ring_fill[tgt]) % RING_SLOTS] = id;
                    ring_fill[tgt]++;
                    res.status = RES_OK;
                end
            end
            MODE_DEQ: begin
                pref = (deq_slot == SLOT_LAST) ? RING_LOW : RING_HIGH;
                tgt  = (ring_fill[pref] != 0) ? pref : 1 - pref;
                if (ring_fill[tgt] == 0) begin
                    res.status = RES_EMPTY;
                end else begin
                    res.item   = ring_slots[tgt][ring_head[tgt]];
                    res.valid  = 1'b1;
                    res.status = RES_OK;
                    // head goes to the tail; with a full ring the tail is the head slot
                    pos = (ring_head[tgt] + ring_fill[tgt]) % RING_SLOTS;
                    ring_slots[tgt][pos] = res.item;
                    ring_head[tgt] = (ring_head[tgt] + 1) % RING_SLOTS;
                end
                deq_slot = (deq_slot >= SLOT_LAST) ? '0 : deq_slot + 1'b1;
            end
            default: ;
        endcase
        return res;
    endfunction

    // Receiver: ready is redrawn at random at the falling edge.
    always @(negedge aclk)
        m_tready = ($urandom_range(0, 99) >= recv_stall_pct);

    // Monitor at the rising edge: check results first, then predict accepted inputs.
    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        outcome_t pred;
        if (!aresetn) begin
            ring_head[RING_HIGH] = 0;
            ring_head[RING_LOW]  = 0;
            ring_fill[RING_HIGH] = 0;
            ring_fill[RING_LOW]  = 0;
            deq_slot             = '0;
            quiet_cycles         = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.item   = m_tdata;
                got.valid  = m_tuser[0];
                got.status = res_t'(m_tuser[2:1]);
                if (pending_outcomes.size() == 0) begin
                    report_mismatch("result with nothing pending", 32'(got), 32'd0);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (got.item !== want.item)
                        report_mismatch("item_out", 32'(got.item), 32'(want.item));
                    if (got.valid !== want.valid)
                        report_mismatch("item_valid", 32'(got.valid), 32'(want.valid));
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                end
            end
            if (s_tvalid && s_tready) begin
                pred = queue_step(mode_t'(s_tuser), s_tdata);
                pending_outcomes.push_back(cur_fixed ? cur_want : pred);
            end
            // watchdog
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Drive one item; entered and left at a falling edge. Valid stays high
    // across back-to-back items.
    task automatic send_item(input mode_t mode, input logic [ITEM_W-1:0] id,
                             input logic fixed, input outcome_t want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid  = 1'b1;
        s_tuser   = mode;
        s_tdata   = id;
        cur_fixed = fixed;
        cur_want  = want;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge aclk);
    endtask

    initial begin
        int unsigned       pick;
        mode_t             mode;
        logic [ITEM_W-1:0] id;

        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // directed rows, no idling
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(DIRECTED[i].mode, DIRECTED[i].id, DIRECTED[i].fixed, DIRECTED[i].want);
        wait_drained();

        // random phases: none, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 40)      mode = MODE_DEQ;
                else if (pick < 68) mode = MODE_ENQ_HIGH;
                else if (pick < 95) mode = MODE_ENQ_LOW;
                else                mode = MODE_NOP;
                // ids: null now and then, reuse of earlier ids for duplicates,
                // otherwise full-range fresh values
                pick = $urandom_range(0, 99);
                if (mode == MODE_DEQ || mode == MODE_NOP)
                    id = ITEM_W'($urandom_range(0, 65535));
                else if (pick < 8)
                    id = '0;
                else if (pick < 55 && enqueued_ids.size() != 0)
                    id = enqueued_ids[$urandom_range(0, enqueued_ids.size() - 1)];
                else
                    id = ITEM_W'($urandom_range(1, 65535));
                if ((mode == MODE_ENQ_HIGH || mode == MODE_ENQ_LOW) && id != '0)
                    enqueued_ids.push_back(id);
                send_item(mode, id, 1'b0, '0);
                // one mid-phase pause until every result is back
                if (n == ITEMS_PER_PHASE / 2 && phase == 1)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge aclk);
        if (pending_outcomes.size() != 0)
            report_mismatch("results never delivered", pending_outcomes.size(), 32'd0);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
